[design/smet_pkg.sv]
// Shared types, constants and saturating helpers for the skew map escape-time core.
package smet_pkg;

  localparam int DATA_WIDTH    = 48;
  localparam int FRAC_BITS     = 32;
  localparam int ITER_WIDTH    = 12;
  localparam int COLOR_WIDTH   = 15;
  localparam int CFG_IDX_WIDTH = 3;
  localparam int STEP_WIDTH    = 4;

  // Operand halves for the partial-product multiplier.
  localparam int MUL_LO_W = DATA_WIDTH / 2;
  localparam int MUL_HI_W = DATA_WIDTH - MUL_LO_W;
  localparam int PROD_W   = 2 * DATA_WIDTH;

  typedef logic signed [DATA_WIDTH-1:0] fx_t;
  typedef logic [ITER_WIDTH-1:0] iter_t;
  typedef logic [STEP_WIDTH-1:0] step_t;

  localparam fx_t FX_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam fx_t FX_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // Whole number in fixed point, clipped to the largest positive value.
  function automatic fx_t const_q(input int unsigned whole);
    logic [PROD_W-1:0] v;
    v = PROD_W'(whole) << FRAC_BITS;
    if (v > PROD_W'(FX_MAX)) begin
      return FX_MAX;
    end
    return v[DATA_WIDTH-1:0];
  endfunction

  localparam fx_t FX_ONE   = const_q(1);
  localparam fx_t FX_LIMIT = const_q(10000);

  localparam int    COLOR_LOW_IMAG = 41;
  localparam int    COLOR_OUTSIDE  = 128;
  localparam int    COLOR_MAX      = 2 * ((1 << ITER_WIDTH) - 2) + COLOR_LOW_IMAG + COLOR_OUTSIDE;
  localparam iter_t MAX_ITER_RESET = ITER_WIDTH'(200);

  // Sequencer steps of one iteration and of the start-up pass.
  localparam step_t STEP_CHECK = STEP_WIDTH'(8);
  localparam step_t INIT_LAST  = STEP_WIDTH'(4);

  function automatic fx_t sat_add(input fx_t a, input fx_t b);
    logic signed [DATA_WIDTH:0] s;
    s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
    if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
      return s[DATA_WIDTH] ? FX_MIN : FX_MAX;
    end
    return s[DATA_WIDTH-1:0];
  endfunction

  function automatic fx_t sat_sub(input fx_t a, input fx_t b);
    logic signed [DATA_WIDTH:0] s;
    s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
    if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
      return s[DATA_WIDTH] ? FX_MIN : FX_MAX;
    end
    return s[DATA_WIDTH-1:0];
  endfunction

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_A_REAL   = 3'd0,
    CFG_A_IMAG   = 3'd1,
    CFG_B_REAL   = 3'd2,
    CFG_B_IMAG   = 3'd3,
    CFG_SKEW     = 3'd4,
    CFG_MAX_ITER = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    fx_t   a_real;
    fx_t   a_imag;
    fx_t   b_real;
    fx_t   b_imag;
    fx_t   skew_gain;
    iter_t max_iterations;
  } cfg_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_XR_XR,
    MUL_XI_XI,
    MUL_S2_DR,
    MUL_S2_DI,
    MUL_YR_YR,
    MUL_YI_YI,
    MUL_UR_YR,
    MUL_UI_YI,
    MUL_UR_YI,
    MUL_UI_YR,
    MUL_XR_PR,
    MUL_XI_PI,
    MUL_XR_PI,
    MUL_XI_PR
  } mul_op_t;

  typedef enum logic [3:0] {
    CAP_NONE,
    CAP_TA,
    CAP_TB,
    CAP_NFLAG,
    CAP_UR,
    CAP_UI,
    CAP_NRM,
    CAP_YR_SUB,
    CAP_YI_ADD,
    CAP_XR_SUB,
    CAP_XI_ADD
  } cap_t;

  typedef struct packed {
    logic    load;
    logic    prep;
    mul_op_t op;
    cap_t    cap;
  } dp_cmd_t;

  typedef struct packed {
    logic stop;
  } dp_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_ITER,
    ST_FINISH
  } ctrl_state_t;

endpackage

[design/skew_map_escape_time_core.sv]
// Top level of the skew map escape-time core: config bank, controller, datapath, output buffer.
//
// One input beat carries a point c; one output beat returns its color index. The
// core iterates y = (y + 2s(a - x)) * y, x = x * (x + b) from x = c, y = c - 1 in
// signed Q16.32 with saturating arithmetic, and stops when |y|^2 reaches 10000 or
// max_iterations steps are done. Color is 2i + 128n (plus 41 when imag(y) <= 0),
// n set when |c|^2 > 1; a bounded orbit returns -1 (all ones in 15 bits).
// Points are handled one at a time. An accepted point goes through the |c|^2 pass,
// then through its iterations, each of which checks |y|^2 and the count midway,
// and once that check stops it, the result is loaded into the output register. At
// most max_iterations iterations are taken (200 after reset); the next point can be
// taken the cycle after the result is loaded. Each iteration runs on the single
// three-stage pipelined 48x48 multiplier, which issues the twelve products of each
// iteration one per cycle in a step schedule that the stop check cuts short. A
// finished result waits in the output register while the next point is accepted;
// if that register still holds an unread result when the next one is done, the
// core holds until the receiver drains it. Write configuration only
// while the core is idle.
module skew_map_escape_time_core import smet_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  // Input stream
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [2*DATA_WIDTH-1:0]   in_tdata,   // [47:0] pixel_real, [95:48] pixel_imag
  // Result stream
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [15:0]               out_tdata,  // [14:0] color_index, [15] zero
  // Configuration write port
  input  logic                      cfg_wr_en,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [DATA_WIDTH-1:0]     cfg_data
);

  cfg_t                   cfg_r, cfg_nxt;
  dp_cmd_t                cmd;
  dp_status_t             status;
  logic                   emit;
  logic                   out_free;
  logic [COLOR_WIDTH-1:0] color;
  logic                   out_valid_r, out_valid_nxt;
  logic [COLOR_WIDTH-1:0] out_color_r, out_color_nxt;

  // Config bank: decode the index, drop writes past the last register.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_A_REAL:   cfg_nxt.a_real         = cfg_data;
        CFG_A_IMAG:   cfg_nxt.a_imag         = cfg_data;
        CFG_B_REAL:   cfg_nxt.b_real         = cfg_data;
        CFG_B_IMAG:   cfg_nxt.b_imag         = cfg_data;
        CFG_SKEW:     cfg_nxt.skew_gain      = cfg_data;
        CFG_MAX_ITER: cfg_nxt.max_iterations = cfg_data[ITER_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.a_real         <= FX_ONE;
      cfg_r.a_imag         <= '0;
      cfg_r.b_real         <= '0;
      cfg_r.b_imag         <= '0;
      cfg_r.skew_gain      <= FX_ONE;
      cfg_r.max_iterations <= MAX_ITER_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  smet_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_free (out_free),
    .status   (status),
    .in_ready (in_tready),
    .emit     (emit),
    .cmd      (cmd)
  );

  smet_dp u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .cfg        (cfg_r),
    .pixel_real (in_tdata[DATA_WIDTH-1:0]),
    .pixel_imag (in_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
    .status     (status),
    .color      (color)
  );

  // Output buffer: take a new color when empty or being drained this cycle.
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_color_nxt = out_color_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_color_nxt = color;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_color_r <= out_color_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_color_r};

  // An accepted point keeps the input side closed on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted again right after a point was taken");

  // A fresh result only follows a cycle in which the core was busy.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared while the core was idle");

  // Color is either the bounded marker or inside the escape range.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[14:0] == '1 || out_tdata[14:0] <= 15'(COLOR_MAX)))
    else $error("color index out of range");

endmodule

[design/smet_mul.sv]
// Three-stage pipelined signed fixed-point multiplier with floor rounding and saturation.
module smet_mul import smet_pkg::*; (
  input  logic clk,
  input  fx_t  op_a,
  input  fx_t  op_b,
  output fx_t  res
);

  logic signed [MUL_LO_W:0]           al, bl;
  logic signed [MUL_HI_W-1:0]         ah, bh;
  logic signed [2*MUL_LO_W+1:0]       pll_nxt, pll_r;
  logic signed [MUL_LO_W+MUL_HI_W:0]  plh_nxt, plh_r, phl_nxt, phl_r;
  logic signed [2*MUL_HI_W-1:0]       phh_nxt, phh_r;
  logic signed [PROD_W-1:0]           ell, elh, ehl, ehh;
  logic signed [PROD_W-1:0]           sum_nxt, sum_r;
  logic [PROD_W-FRAC_BITS-DATA_WIDTH:0] upper;
  fx_t                                res_nxt, res_r;

  // Stage 1: four partial products, low halves taken as unsigned.
  assign al = {1'b0, op_a[MUL_LO_W-1:0]};
  assign bl = {1'b0, op_b[MUL_LO_W-1:0]};
  assign ah = op_a[DATA_WIDTH-1:MUL_LO_W];
  assign bh = op_b[DATA_WIDTH-1:MUL_LO_W];

  assign pll_nxt = al * bl;
  assign plh_nxt = al * bh;
  assign phl_nxt = ah * bl;
  assign phh_nxt = ah * bh;

  // Stage 2: align and sum the exact product.
  assign ell = pll_r;
  assign elh = plh_r;
  assign ehl = phl_r;
  assign ehh = phh_r;
  assign sum_nxt = ell + (elh <<< MUL_LO_W) + (ehl <<< MUL_LO_W) + (ehh <<< (2 * MUL_LO_W));

  // Stage 3: arithmetic shift is floor; clip when the upper bits are not a sign run.
  assign upper = sum_r[PROD_W-1:FRAC_BITS+DATA_WIDTH-1];

  always_comb begin
    if ((&upper) || !(|upper)) begin
      res_nxt = sum_r[FRAC_BITS+DATA_WIDTH-1:FRAC_BITS];
    end else begin
      res_nxt = sum_r[PROD_W-1] ? FX_MIN : FX_MAX;
    end
  end

  always_ff @(posedge clk) begin
    pll_r <= pll_nxt;
    plh_r <= plh_nxt;
    phl_r <= phl_nxt;
    phh_r <= phh_nxt;
    sum_r <= sum_nxt;
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

[design/smet_dp.sv]
// Datapath: orbit registers, operand select, result capture and color formation.
module smet_dp import smet_pkg::*; (
  input  logic                    clk,
  input  dp_cmd_t                 cmd,
  input  cfg_t                    cfg,
  input  fx_t                     pixel_real,
  input  fx_t                     pixel_imag,
  output dp_status_t              status,
  output logic [COLOR_WIDTH-1:0]  color
);

  fx_t   xr_r, xr_nxt, xi_r, xi_nxt, yr_r, yr_nxt, yi_r, yi_nxt;
  fx_t   dr_r, dr_nxt, di_r, di_nxt, pr_r, pr_nxt, pi_r, pi_nxt;
  fx_t   s2_r, s2_nxt, ur_r, ur_nxt, ui_r, ui_nxt;
  fx_t   ta_r, ta_nxt, tb_r, tb_nxt, nrm_r, nrm_nxt;
  logic  nflag_r, nflag_nxt;
  iter_t iter_r, iter_nxt;
  fx_t   mul_a, mul_b, mul_res;
  logic [COLOR_WIDTH-1:0] escape_color;

  smet_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .res  (mul_res)
  );

  always_comb begin
    case (cmd.op)
      MUL_XR_XR: begin mul_a = xr_r; mul_b = xr_r; end
      MUL_XI_XI: begin mul_a = xi_r; mul_b = xi_r; end
      MUL_S2_DR: begin mul_a = s2_r; mul_b = dr_r; end
      MUL_S2_DI: begin mul_a = s2_r; mul_b = di_r; end
      MUL_YR_YR: begin mul_a = yr_r; mul_b = yr_r; end
      MUL_YI_YI: begin mul_a = yi_r; mul_b = yi_r; end
      MUL_UR_YR: begin mul_a = ur_r; mul_b = yr_r; end
      MUL_UI_YI: begin mul_a = ui_r; mul_b = yi_r; end
      MUL_UR_YI: begin mul_a = ur_r; mul_b = yi_r; end
      MUL_UI_YR: begin mul_a = ui_r; mul_b = yr_r; end
      MUL_XR_PR: begin mul_a = xr_r; mul_b = pr_r; end
      MUL_XI_PI: begin mul_a = xi_r; mul_b = pi_r; end
      MUL_XR_PI: begin mul_a = xr_r; mul_b = pi_r; end
      MUL_XI_PR: begin mul_a = xi_r; mul_b = pr_r; end
      default:   begin mul_a = '0;   mul_b = '0;   end
    endcase
  end

  always_comb begin
    xr_nxt    = xr_r;
    xi_nxt    = xi_r;
    yr_nxt    = yr_r;
    yi_nxt    = yi_r;
    dr_nxt    = dr_r;
    di_nxt    = di_r;
    pr_nxt    = pr_r;
    pi_nxt    = pi_r;
    s2_nxt    = s2_r;
    ur_nxt    = ur_r;
    ui_nxt    = ui_r;
    ta_nxt    = ta_r;
    tb_nxt    = tb_r;
    nrm_nxt   = nrm_r;
    nflag_nxt = nflag_r;
    iter_nxt  = iter_r;

    if (cmd.load) begin
      xr_nxt   = pixel_real;
      xi_nxt   = pixel_imag;
      yr_nxt   = sat_sub(pixel_real, FX_ONE);
      yi_nxt   = pixel_imag;
      s2_nxt   = sat_add(cfg.skew_gain, cfg.skew_gain);
      iter_nxt = '0;
    end

    if (cmd.prep) begin
      dr_nxt = sat_sub(cfg.a_real, xr_r);
      di_nxt = sat_sub(cfg.a_imag, xi_r);
      pr_nxt = sat_add(xr_r, cfg.b_real);
      pi_nxt = sat_add(xi_r, cfg.b_imag);
    end

    case (cmd.cap)
      CAP_TA:     ta_nxt    = mul_res;
      CAP_TB:     tb_nxt    = mul_res;
      CAP_NFLAG:  nflag_nxt = sat_add(ta_r, mul_res) > FX_ONE;
      CAP_UR:     ur_nxt    = sat_add(yr_r, mul_res);
      CAP_UI:     ui_nxt    = sat_add(yi_r, mul_res);
      CAP_NRM:    nrm_nxt   = sat_add(ta_r, mul_res);
      CAP_YR_SUB: yr_nxt    = sat_sub(ta_r, mul_res);
      CAP_YI_ADD: yi_nxt    = sat_add(tb_r, mul_res);
      CAP_XR_SUB: xr_nxt    = sat_sub(ta_r, mul_res);
      CAP_XI_ADD: begin
        xi_nxt   = sat_add(tb_r, mul_res);
        iter_nxt = iter_r + ITER_WIDTH'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    xr_r    <= xr_nxt;
    xi_r    <= xi_nxt;
    yr_r    <= yr_nxt;
    yi_r    <= yi_nxt;
    dr_r    <= dr_nxt;
    di_r    <= di_nxt;
    pr_r    <= pr_nxt;
    pi_r    <= pi_nxt;
    s2_r    <= s2_nxt;
    ur_r    <= ur_nxt;
    ui_r    <= ui_nxt;
    ta_r    <= ta_nxt;
    tb_r    <= tb_nxt;
    nrm_r   <= nrm_nxt;
    nflag_r <= nflag_nxt;
    iter_r  <= iter_nxt;
  end

  // Stop when the limit is reached or the current y has left the disk.
  assign status.stop = (iter_r >= cfg.max_iterations) || (nrm_r >= FX_LIMIT);

  assign escape_color = COLOR_WIDTH'({iter_r, 1'b0})
                      + ((yi_r > 0) ? COLOR_WIDTH'(0) : COLOR_WIDTH'(COLOR_LOW_IMAG))
                      + (nflag_r ? COLOR_WIDTH'(COLOR_OUTSIDE) : COLOR_WIDTH'(0));

  assign color = (iter_r < cfg.max_iterations) ? escape_color : '1;

endmodule

[design/smet_ctrl.sv]
// Controller: sequences the start-up pass and the per-iteration multiply schedule.
module smet_ctrl import smet_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       out_free,
  input  dp_status_t status,
  output logic       in_ready,
  output logic       emit,
  output dp_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;
  step_t       step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    in_ready  = 1'b0;
    emit      = 1'b0;
    cmd.load  = 1'b0;
    cmd.prep  = 1'b0;
    cmd.op    = MUL_NONE;
    cmd.cap   = CAP_NONE;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_INIT;
          step_nxt  = '0;
        end
      end

      // |c|^2 for the outside flag.
      ST_INIT: begin
        case (step_r)
          4'd0:    cmd.op  = MUL_XR_XR;
          4'd1:    cmd.op  = MUL_XI_XI;
          4'd3:    cmd.cap = CAP_TA;
          4'd4:    cmd.cap = CAP_NFLAG;
          default: ;
        endcase
        step_nxt = step_r + STEP_WIDTH'(1);
        if (step_r == INIT_LAST) begin
          state_nxt = ST_ITER;
          step_nxt  = '0;
        end
      end

      // Issue one product a step; each result is captured as it leaves the multiplier pipeline.
      ST_ITER: begin
        case (step_r)
          4'd0:  cmd.prep = 1'b1;
          4'd1:  cmd.op = MUL_S2_DR;
          4'd2:  cmd.op = MUL_S2_DI;
          4'd3:  cmd.op = MUL_YR_YR;
          4'd4:  begin cmd.op = MUL_YI_YI; cmd.cap = CAP_UR;     end
          4'd5:  begin cmd.op = MUL_UR_YR; cmd.cap = CAP_UI;     end
          4'd6:  begin cmd.op = MUL_UI_YI; cmd.cap = CAP_TA;     end
          4'd7:  begin cmd.op = MUL_UR_YI; cmd.cap = CAP_NRM;    end
          4'd8:  begin cmd.op = MUL_UI_YR; cmd.cap = CAP_TA;     end
          4'd9:  begin cmd.op = MUL_XR_PR; cmd.cap = CAP_YR_SUB; end
          4'd10: begin cmd.op = MUL_XI_PI; cmd.cap = CAP_TB;     end
          4'd11: begin cmd.op = MUL_XR_PI; cmd.cap = CAP_YI_ADD; end
          4'd12: begin cmd.op = MUL_XI_PR; cmd.cap = CAP_TA;     end
          4'd13: cmd.cap = CAP_XR_SUB;
          4'd14: cmd.cap = CAP_TB;
          4'd15: cmd.cap = CAP_XI_ADD;
          default: ;
        endcase
        step_nxt = step_r + STEP_WIDTH'(1);
        if ((step_r == STEP_CHECK) && status.stop) begin
          state_nxt = ST_FINISH;
          step_nxt  = '0;
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

endmodule
